// ----- rtl/bcrf_pkg.sv -----
// Package for the border-connected region fill block.
// Holds grid sizes, register indexes, the sequencer state type and the
// row-unit transaction structs. No dependencies.
`default_nettype none

package bcrf_pkg;

    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 32;
    localparam int ROW_W    = 32;
    localparam int IDX_W    = 5;
    localparam int CNT_W    = 6;
    localparam int CFG_W    = 6;
    localparam int OUT_W    = 40;

    localparam logic CFG_GRID_ROWS = 1'b0;
    localparam logic CFG_GRID_COLS = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_PROP,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_state;

    typedef struct packed {
        logic              init;
        logic              border_row;
        logic [ROW_W-1:0]  edge_bits;
        logic [ROW_W-1:0]  open_row;
        logic [ROW_W-1:0]  cur_row;
        logic [ROW_W-1:0]  prev_row;
        logic [ROW_W-1:0]  next_row;
    } t_row_op;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic              changed;
    } t_row_res;

    function automatic logic [CNT_W-1:0] eff_rows(input logic [CFG_W-1:0] value);
        logic [CNT_W-1:0] r;
        r = value;
        if (r == '0) begin
            r = CNT_W'(1);
        end else if (r > CNT_W'(MAX_ROWS)) begin
            r = CNT_W'(MAX_ROWS);
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] eff_cols(input logic [CFG_W-1:0] value);
        logic [CNT_W-1:0] c;
        c = value;
        if (c == '0) begin
            c = CNT_W'(1);
        end else if (c > CNT_W'(MAX_COLS)) begin
            c = CNT_W'(MAX_COLS);
        end
        return c;
    endfunction

    function automatic logic [ROW_W-1:0] col_mask(input logic [CNT_W-1:0] cols);
        logic [CNT_W-1:0] sh;
        sh = CNT_W'(ROW_W) - cols;
        return {ROW_W{1'b1}} >> sh;
    endfunction

    function automatic logic [ROW_W-1:0] edge_mask(input logic [CNT_W-1:0] cols);
        logic [CNT_W-1:0] sh;
        sh = cols - CNT_W'(1);
        return ROW_W'(1) | (ROW_W'(1) << sh);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bcrf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the cell store and the reached store. No dependencies.
`default_nettype none

module bcrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/bcrf_row_unit.sv -----
// Shared row unit: seeds a row's reached set from its open cells, or grows
// it by one 4-neighbor step. Depends on bcrf_pkg.
`default_nettype none

module bcrf_row_unit (
    input  wire bcrf_pkg::t_row_op  i_op,
    output bcrf_pkg::t_row_res      o_res
);

    logic [bcrf_pkg::ROW_W-1:0] near;
    logic [bcrf_pkg::ROW_W-1:0] grown;
    logic [bcrf_pkg::ROW_W-1:0] seed;

    always_comb begin
        near  = (i_op.cur_row << 1) | (i_op.cur_row >> 1) | i_op.prev_row | i_op.next_row;
        grown = i_op.cur_row | (near & i_op.open_row);
        seed  = i_op.border_row ? i_op.open_row : (i_op.open_row & i_op.edge_bits);
        o_res.row     = i_op.init ? seed : grown;
        o_res.changed = !i_op.init && (grown != i_op.cur_row);
    end

endmodule

`default_nettype wire

// ----- rtl/border_connected_region_fill.sv -----
// Top level of the border-connected region fill: sequencer, config registers,
// cell and reached stores. Depends on bcrf_pkg, bcrf_ram and bcrf_row_unit.
//
//  Channel   Signals                                   Role
//  s_axis    tvalid, tready, tdata[31:0]=row_cells     one grid row per transaction
//  m_axis    tvalid, tready, tdata, tlast=last_row     one filled row per transaction
//  cfg       i_cfg_we, i_cfg_idx, i_cfg_wdata[5:0]     grid_rows (0), grid_cols (1)
//
// Rows load at one per cycle. After the last row, a seed sweep and then propagation
// sweeps run through the shared row unit; sweeps repeat until one changes nothing.
// Each output row goes through a read state and then an offer state.
// Reset is synchronous and active low; the stores need no clearing.
// The input side is not ready from the last row until the last output row is taken.
`default_nettype none

module border_connected_region_fill (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [bcrf_pkg::ROW_W-1:0]    s_axis_tdata,   // [31:0] row_cells
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [bcrf_pkg::OUT_W-1:0]    m_axis_tdata,   // [31:0] out_cells, [36:32] out_row_index
    output logic                               m_axis_tlast,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [bcrf_pkg::CFG_W-1:0]    i_cfg_wdata
);

    bcrf_pkg::t_state               r_state, n_state;
    logic [bcrf_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [bcrf_pkg::CNT_W-1:0]     r_load_cnt, n_load_cnt;
    logic                           r_changed, n_changed;
    logic [bcrf_pkg::ROW_W-1:0]     r_prev, n_prev;
    logic [bcrf_pkg::ROW_W-1:0]     r_cur, n_cur;
    logic [bcrf_pkg::ROW_W-1:0]     r_open, n_open;
    logic [bcrf_pkg::CFG_W-1:0]     r_grid_rows;
    logic [bcrf_pkg::CFG_W-1:0]     r_grid_cols;

    logic [bcrf_pkg::CNT_W-1:0]     rows;
    logic [bcrf_pkg::CNT_W-1:0]     cols;
    logic [bcrf_pkg::ROW_W-1:0]     cmask;
    logic [bcrf_pkg::ROW_W-1:0]     emask;
    logic [bcrf_pkg::CNT_W-1:0]     cnt_m1;
    logic [bcrf_pkg::CNT_W-1:0]     cnt_m2;
    logic [bcrf_pkg::CNT_W-1:0]     load_p1;
    logic                           in_acc;
    logic                           out_acc;
    logic                           last_row;

    logic                           reach_we;
    logic [bcrf_pkg::IDX_W-1:0]     reach_waddr;
    logic [bcrf_pkg::ROW_W-1:0]     rd_reach;
    logic [bcrf_pkg::ROW_W-1:0]     rd_cell;

    bcrf_pkg::t_row_op              op;
    bcrf_pkg::t_row_res             res;

    assign rows     = bcrf_pkg::eff_rows(r_grid_rows);
    assign cols     = bcrf_pkg::eff_cols(r_grid_cols);
    assign cmask    = bcrf_pkg::col_mask(cols);
    assign emask    = bcrf_pkg::edge_mask(cols);
    assign cnt_m1   = r_cnt - bcrf_pkg::CNT_W'(1);
    assign cnt_m2   = r_cnt - bcrf_pkg::CNT_W'(2);
    assign load_p1  = r_load_cnt + bcrf_pkg::CNT_W'(1);
    assign last_row = (r_cnt == rows - bcrf_pkg::CNT_W'(1));

    assign s_axis_tready = (r_state == bcrf_pkg::ST_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_state == bcrf_pkg::ST_EMIT_OUT);
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = {3'b000, r_cnt[bcrf_pkg::IDX_W-1:0], rd_reach};
    assign m_axis_tlast  = last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= bcrf_pkg::CFG_W'(bcrf_pkg::MAX_ROWS);
            r_grid_cols <= bcrf_pkg::CFG_W'(bcrf_pkg::MAX_COLS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bcrf_pkg::CFG_GRID_ROWS: r_grid_rows <= i_cfg_wdata;
                bcrf_pkg::CFG_GRID_COLS: r_grid_cols <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bcrf_pkg::ST_LOAD;
            r_cnt      <= '0;
            r_load_cnt <= '0;
            r_changed  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_load_cnt <= n_load_cnt;
            r_changed  <= n_changed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_open <= n_open;
    end

    always_comb begin
        op.init       = (r_state == bcrf_pkg::ST_INIT);
        op.border_row = (cnt_m1 == '0) || (cnt_m1 == rows - bcrf_pkg::CNT_W'(1));
        op.edge_bits  = emask;
        op.open_row   = op.init ? (rd_cell & cmask) : r_open;
        op.cur_row    = r_cur;
        op.prev_row   = r_prev;
        op.next_row   = (r_cnt <= rows) ? rd_reach : '0;
    end

    bcrf_row_unit u_row_unit (
        .i_op  (op),
        .o_res (res)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_load_cnt  = r_load_cnt;
        n_changed   = r_changed;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_open      = r_open;
        reach_we    = 1'b0;
        reach_waddr = cnt_m1[bcrf_pkg::IDX_W-1:0];
        unique case (r_state)
            bcrf_pkg::ST_LOAD: begin
                if (in_acc) begin
                    if (load_p1 >= rows) begin
                        n_load_cnt = '0;
                        n_cnt      = '0;
                        n_state    = bcrf_pkg::ST_INIT;
                    end else begin
                        n_load_cnt = load_p1;
                    end
                end
            end
            bcrf_pkg::ST_INIT: begin
                reach_we = (r_cnt != '0);
                if (r_cnt == rows) begin
                    n_cnt     = '0;
                    n_changed = 1'b0;
                    n_state   = bcrf_pkg::ST_PROP;
                end else begin
                    n_cnt = r_cnt + bcrf_pkg::CNT_W'(1);
                end
            end
            bcrf_pkg::ST_PROP: begin
                reach_waddr = cnt_m2[bcrf_pkg::IDX_W-1:0];
                if (r_cnt == '0) begin
                    n_prev    = '0;
                    n_changed = 1'b0;
                end else begin
                    n_cur  = rd_reach;
                    n_open = rd_cell & cmask;
                end
                if (r_cnt >= bcrf_pkg::CNT_W'(2)) begin
                    reach_we  = 1'b1;
                    n_prev    = res.row;
                    n_changed = r_changed || res.changed;
                end
                if (r_cnt == rows + bcrf_pkg::CNT_W'(1)) begin
                    n_cnt   = '0;
                    n_state = (r_changed || res.changed) ? bcrf_pkg::ST_PROP
                                                         : bcrf_pkg::ST_EMIT_RD;
                end else begin
                    n_cnt = r_cnt + bcrf_pkg::CNT_W'(1);
                end
            end
            bcrf_pkg::ST_EMIT_RD: begin
                n_state = bcrf_pkg::ST_EMIT_OUT;
            end
            bcrf_pkg::ST_EMIT_OUT: begin
                if (out_acc) begin
                    if (last_row) begin
                        n_cnt   = '0;
                        n_state = bcrf_pkg::ST_LOAD;
                    end else begin
                        n_cnt   = r_cnt + bcrf_pkg::CNT_W'(1);
                        n_state = bcrf_pkg::ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = bcrf_pkg::ST_LOAD;
            end
        endcase
    end

    bcrf_ram #(
        .WIDTH (bcrf_pkg::ROW_W),
        .DEPTH (bcrf_pkg::MAX_ROWS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_load_cnt[bcrf_pkg::IDX_W-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_cnt[bcrf_pkg::IDX_W-1:0]),
        .o_rdata (rd_cell)
    );

    bcrf_ram #(
        .WIDTH (bcrf_pkg::ROW_W),
        .DEPTH (bcrf_pkg::MAX_ROWS)
    ) u_reach_ram (
        .i_clk   (i_clk),
        .i_we    (reach_we),
        .i_waddr (reach_waddr),
        .i_wdata (res.row),
        .i_raddr (r_cnt[bcrf_pkg::IDX_W-1:0]),
        .o_rdata (rd_reach)
    );

`ifndef NO_ASSERTIONS
    a_sides_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is offered");

    a_last_returns_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && m_axis_tlast) |=> s_axis_tready)
        else $error("block did not return to loading after the last row");

    a_load_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_cnt < bcrf_pkg::CNT_W'(bcrf_pkg::MAX_ROWS))
        else $error("load count beyond the store depth");

    a_emit_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_cnt < rows))
        else $error("emitted row index beyond the grid");

    a_reach_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        reach_we |-> (r_state == bcrf_pkg::ST_INIT || r_state == bcrf_pkg::ST_PROP))
        else $error("reached store written outside a sweep");
`endif

endmodule

`default_nettype wire

// ----- tb/bcrf_fill_checker.sv -----
`timescale 1ns / 100ps
// Checker for border_connected_region_fill. It follows the config, row-input and
// filled-row channels, predicts every filled row and compares it with the output.
// Depends on bcrf_pkg.
module bcrf_fill_checker
    import bcrf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    input  wire logic             i_s_tready,
    input  wire logic [ROW_W-1:0] i_s_tdata,
    input  wire logic             i_m_tvalid,
    input  wire logic             i_m_tready,
    input  wire logic [OUT_W-1:0] i_m_tdata,
    input  wire logic             i_m_tlast,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    output int                    o_mismatches,
    output int                    o_pending
);

    typedef struct packed {
        logic [ROW_W-1:0] cells;
        logic [IDX_W-1:0] row_num;
        logic             last;
    } t_filled_row;

    t_filled_row      filled_rows_due[$];
    logic [ROW_W-1:0] loaded_rows [MAX_ROWS];
    int               rows_loaded;
    logic [CFG_W-1:0] rows_setting;
    logic [CFG_W-1:0] cols_setting;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic int clamp_size(input logic [CFG_W-1:0] value, input int top);
        int n;
        n = int'(value);
        if (n < 1) begin
            n = 1;
        end else if (n > top) begin
            n = top;
        end
        return n;
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        $display("%0t: %s: got %h, expected %h", $time, what, got, want);
        o_mismatches++;
    endtask

    // Seeds the reached set from the open border cells, grows it through open
    // 4-neighbours until it settles, and queues the surviving rows.
    task automatic fill_grid(input int n_rows, input int n_cols);
        logic [ROW_W-1:0] col_bits;
        logic [ROW_W-1:0] border_cols;
        logic [ROW_W-1:0] open_cells;
        logic [ROW_W-1:0] grown;
        logic [ROW_W-1:0] reach [MAX_ROWS];
        bit               moved;
        int               r;
        t_filled_row      item;
        col_bits    = (n_cols == ROW_W) ? '1 : ((ROW_W'(1) << n_cols) - ROW_W'(1));
        border_cols = ROW_W'(1) | (ROW_W'(1) << (n_cols - 1));
        for (r = 0; r < n_rows; r++) begin
            open_cells = loaded_rows[r] & col_bits;
            reach[r] = (r == 0 || r == n_rows - 1) ? open_cells : (open_cells & border_cols);
        end
        do begin
            moved = 1'b0;
            for (r = 0; r < n_rows; r++) begin
                grown = (reach[r] << 1) | (reach[r] >> 1);
                if (r > 0) begin
                    grown |= reach[r-1];
                end
                if (r < n_rows - 1) begin
                    grown |= reach[r+1];
                end
                grown = reach[r] | (grown & loaded_rows[r] & col_bits);
                if (grown != reach[r]) begin
                    reach[r] = grown;
                    moved = 1'b1;
                end
            end
        end while (moved);
        for (r = 0; r < n_rows; r++) begin
            item.cells   = reach[r];
            item.row_num = IDX_W'(r);
            item.last    = (r == n_rows - 1);
            filled_rows_due.push_back(item);
        end
    endtask

    always @(posedge i_clk) begin
        t_filled_row want;
        if (!i_rst_n) begin
            filled_rows_due.delete();
            rows_loaded  = 0;
            rows_setting = CFG_W'(MAX_ROWS);
            cols_setting = CFG_W'(MAX_COLS);
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_GRID_ROWS) begin
                    rows_setting = i_cfg_wdata;
                end else begin
                    cols_setting = i_cfg_wdata;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (rows_loaded < MAX_ROWS) begin
                    loaded_rows[rows_loaded] = i_s_tdata;
                end
                rows_loaded++;
                if (rows_loaded >= clamp_size(rows_setting, MAX_ROWS)) begin
                    fill_grid(clamp_size(rows_setting, MAX_ROWS),
                              clamp_size(cols_setting, MAX_COLS));
                    rows_loaded = 0;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (filled_rows_due.size() == 0) begin
                    report_mismatch("output row with none expected", i_m_tdata, '0);
                end else begin
                    want = filled_rows_due.pop_front();
                    if (i_m_tdata[ROW_W-1:0] != want.cells) begin
                        report_mismatch("out_cells", OUT_W'(i_m_tdata[ROW_W-1:0]),
                                        OUT_W'(want.cells));
                    end
                    if (i_m_tdata[ROW_W+IDX_W-1:ROW_W] != want.row_num) begin
                        report_mismatch("out_row_index",
                                        OUT_W'(i_m_tdata[ROW_W+IDX_W-1:ROW_W]),
                                        OUT_W'(want.row_num));
                    end
                    if (i_m_tdata[OUT_W-1:ROW_W+IDX_W] != '0) begin
                        report_mismatch("tdata padding", i_m_tdata, '0);
                    end
                    if (i_m_tlast != want.last) begin
                        report_mismatch("last_row", OUT_W'(i_m_tlast), OUT_W'(want.last));
                    end
                end
            end
        end
        o_pending = filled_rows_due.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for border_connected_region_fill: clock, reset, grid stimulus,
// receiver back-pressure and the verdict. Depends on bcrf_pkg and bcrf_fill_checker.
module tb;
    import bcrf_pkg::*;

    localparam int CYCLE_LIMIT    = 1500000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 40;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [ROW_W-1:0] s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tlast;
    logic             i_cfg_we      = 1'b0;
    logic             i_cfg_idx     = CFG_GRID_ROWS;
    logic [CFG_W-1:0] i_cfg_wdata   = '0;

    int mismatches;
    int rows_pending;
    int cycle_count   = 0;
    int rows_sent     = 0;
    int send_idle_pct = 23;
    int recv_idle_pct = 76;
    int holds_asked   = 0;
    int holds_done    = 0;

    border_connected_region_fill u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    bcrf_fill_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (rows_pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (holds_asked != holds_done) begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_row(input logic [ROW_W-1:0] cells);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cells;
        do @(posedge i_clk); while (!s_axis_tready);
        rows_sent++;
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (rows_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [ROW_W-1:0] random_row();
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3:    return a & b;
            4, 5:    return a | b;
            default: return a;
        endcase
    endfunction

    task automatic run_random_setting();
        logic [CFG_W-1:0] rows_val;
        logic [CFG_W-1:0] cols_val;
        int               pick;
        int               grid_len;
        int               grids;
        int               k;
        pick = $urandom_range(99);
        if (pick < 5) begin
            rows_val = '0;
        end else if (pick < 10) begin
            rows_val = CFG_W'($urandom_range(63, MAX_ROWS + 1));
        end else if (pick < 16) begin
            rows_val = CFG_W'(MAX_ROWS);
        end else if (pick < 24) begin
            rows_val = CFG_W'($urandom_range(MAX_ROWS - 1, 9));
        end else begin
            rows_val = CFG_W'($urandom_range(8, 1));
        end
        pick = $urandom_range(99);
        if (pick < 8) begin
            cols_val = '0;
        end else if (pick < 16) begin
            cols_val = CFG_W'($urandom_range(63, MAX_COLS + 1));
        end else if (pick < 26) begin
            cols_val = CFG_W'(MAX_COLS);
        end else if (pick < 32) begin
            cols_val = CFG_W'(1);
        end else begin
            cols_val = CFG_W'($urandom_range(MAX_COLS - 1, 2));
        end
        write_reg(CFG_GRID_ROWS, rows_val);
        write_reg(CFG_GRID_COLS, cols_val);
        grid_len = (rows_val == 0) ? 1 : ((rows_val > MAX_ROWS) ? MAX_ROWS : int'(rows_val));
        grids = (grid_len > 16) ? 1 : $urandom_range(3, 1);
        for (k = 0; k < grids * grid_len; k++) begin
            send_row(random_row());
        end
    endtask

    initial begin
        int phase;
        int k;
        int phase_end [3];
        phase_end = '{100, 175, 250};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero sizes are taken as one row and one column.
        write_reg(CFG_GRID_ROWS, '0);
        write_reg(CFG_GRID_COLS, '0);
        send_row('1);
        send_row('0);
        // A single full-width row is all border.
        write_reg(CFG_GRID_ROWS, CFG_W'(1));
        write_reg(CFG_GRID_COLS, CFG_W'(MAX_COLS));
        send_row('1);
        send_row(32'h8000_0001);
        // A small board with one enclosed region, junk above the used columns.
        write_reg(CFG_GRID_ROWS, CFG_W'(4));
        write_reg(CFG_GRID_COLS, CFG_W'(4));
        send_row(32'hA5A5_A5A0);
        send_row(32'hA5A5_A5A6);
        send_row(32'hA5A5_A5A4);
        send_row(32'hA5A5_A5A2);
        // Oversized column counts saturate.
        write_reg(CFG_GRID_ROWS, CFG_W'(2));
        write_reg(CFG_GRID_COLS, 6'd63);
        send_row('1);
        send_row(32'h7FFF_FFFE);
        write_reg(CFG_GRID_COLS, CFG_W'(MAX_COLS - 1));
        send_row(32'h5555_5555);
        send_row(32'hAAAA_AAAA);
        // Row count lowered below the rows already loaded.
        write_reg(CFG_GRID_ROWS, CFG_W'(6));
        send_row(32'h0FF0_0FF0);
        send_row(32'hF00F_F00F);
        send_row(32'h3C3C_3C3C);
        write_reg(CFG_GRID_ROWS, CFG_W'(2));
        send_row(32'hFFFF_0000);

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 23 : ((phase == 1) ? 76 : 0);
            recv_idle_pct = (phase == 0) ? 76 : ((phase == 1) ? 23 : 0);
            if (phase == 2) begin
                write_reg(CFG_GRID_ROWS, CFG_W'(8));
                write_reg(CFG_GRID_COLS, CFG_W'(MAX_COLS));
                holds_asked++;
                for (k = 0; k < 24; k++) begin
                    send_row(random_row());
                end
            end
            while (rows_sent < phase_end[phase]) begin
                run_random_setting();
            end
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (rows_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bcrf_pkg.sv
rtl/bcrf_ram.sv
rtl/bcrf_row_unit.sv
rtl/border_connected_region_fill.sv
tb/bcrf_fill_checker.sv
tb/tb.sv
